[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros used by the RTL of the maze set merger
// Clocked concurrent checks on clk, with and without reset gating.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every rising edge of clk, suspended while arst_n is low
`define GMS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// check on every rising edge of clk, reset included
`define GMS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/gms_pkg.sv]
// ---------------------------------------------------------------------------
// gms_pkg
// Types, codes and helpers of the maze set merger.
// ---------------------------------------------------------------------------
package gms_pkg;

	localparam int MAX_SIDE_DEF = 64;
	localparam int LW = 13;

	localparam logic [LW-1:0] CODE_WALL  = 13'h1FFF;
	localparam logic [LW-1:0] CODE_START = 13'h1FFE;
	localparam logic [LW-1:0] CODE_OPEN  = 13'h0000;

	localparam logic [1:0] OP_START  = 2'd0;
	localparam logic [1:0] OP_TRY    = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic [1:0] KIND_EMPTY = 2'd0;
	localparam logic [1:0] KIND_WALL  = 2'd1;
	localparam logic [1:0] KIND_START = 2'd2;

	localparam logic REG_GRID_WIDTH  = 1'b0;
	localparam logic REG_GRID_HEIGHT = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PROBE,
		ST_DECIDE,
		ST_SWEEP,
		ST_FINISH
	} state_t;

	function automatic logic is_label(input logic [LW-1:0] v);
		return (v != CODE_OPEN) && (v < CODE_START);
	endfunction

endpackage

[rtl/gms_ram.sv]
// ---------------------------------------------------------------------------
// gms_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module gms_ram #(
	parameter int DW = 13,
	parameter int AW = 12
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

[rtl/grid_maze_set_merger.sv]
// ---------------------------------------------------------------------------
// grid_maze_set_merger
// Set-merging core of a Kruskal maze generator over a grid label store.
// ---------------------------------------------------------------------------
// Usage:
// Items arrive on in_valid/in_stall with opcode, pos_x and pos_y; each item
// gives exactly one result beat on out_valid/out_stall (cell_kind, merged,
// done_res). Grid sizes are set through cfg_we/cfg_index/cfg_data; the user
// must write them only while idle, as the block itself does not enforce it.
// Each item runs from accept to result through neighbour reads, a decision,
// a sweep over all W*H cells through the single read port of the label
// store, and a finish step. A start item builds the grid in that sweep, a try
// that merges relabels in it, and every opcode checks the set count in it.
// An item can be accepted as soon as the previous result is posted.
// One item is worked on at a time; the next item is taken while a result
// still waits in the output register. When out_stall holds the result, the
// block finishes the current item and then waits with in_stall high.
// Reset clears the control state and sets both sizes to 63; the label store
// holds no valid data until the first start item.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module grid_maze_set_merger #(
	parameter int MAX_SIDE = gms_pkg::MAX_SIDE_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [5:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] opcode,
	input  logic [5:0] pos_x,
	input  logic [5:0] pos_y,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] cell_kind,
	output logic       merged,
	output logic       done_res
);

	localparam int CW = $clog2(MAX_SIDE);
	localparam int SW = $clog2(MAX_SIDE + 1);
	localparam int KW = ((SW > 6) ? SW : 6) + 1;
	localparam int AW = 2 * CW;
	localparam int LW = gms_pkg::LW;

	gms_pkg::state_t state_q, state_d;

	logic [5:0] grid_width_q, grid_height_q;
	logic [KW-1:0] w_raw, h_raw, w_k, h_k, px_k, py_k;
	logic [CW-1:0] wm1, wm2, hm1, hm2;

	logic [1:0] op_q;
	logic [5:0] px_q, py_q;
	logic [CW-1:0] cx, cy;
	logic [2:0] pc_q;
	logic [LW-1:0] p_q [5];

	logic build_q, relabel_q, issue_q;
	logic [LW-1:0] keep_q, gone_q, nl_q, up_q;
	logic [1:0] kind_q;
	logic [CW-1:0] sx_q, sy_q;
	logic v_s1, last_s1;
	logic [CW-1:0] x_s1, y_s1;
	logic have_q, ok_q;
	logic [LW-1:0] first_q;

	logic out_valid_q;
	logic [1:0] cell_kind_q;
	logic merged_q, done_res_q;

	logic mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [LW-1:0] mem_wdata, mem_rd;
	logic cb_we;
	logic [LW-1:0] cb_rd;

	logic accept, out_free, sweep_last;
	logic interior, lr_bad, ud_bad, merge_d;
	logic [LW-1:0] keep_d, gone_d;
	logic [1:0] kind_d;
	logic col_open, row_open, cell_open, left_lab, up_lab, take_nl, entry_hit;
	logic [LW-1:0] bval, nv;

	// effective sizes
	always_comb begin
		w_raw = KW'(grid_width_q);
		h_raw = KW'(grid_height_q);
		w_k = (w_raw < KW'(5)) ? KW'(5) : (w_raw > KW'(MAX_SIDE)) ? KW'(MAX_SIDE) : w_raw;
		h_k = (h_raw < KW'(5)) ? KW'(5) : (h_raw > KW'(MAX_SIDE)) ? KW'(MAX_SIDE) : h_raw;
		wm1 = CW'(w_k - KW'(1));
		wm2 = CW'(w_k - KW'(2));
		hm1 = CW'(h_k - KW'(1));
		hm2 = CW'(h_k - KW'(2));
		px_k = KW'(px_q);
		py_k = KW'(py_q);
		cx = CW'(px_q);
		cy = CW'(py_q);
	end

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != gms_pkg::ST_IDLE);
	assign out_free = !(out_valid_q && out_stall);
	assign sweep_last = (sx_q == wm1) && (sy_q == hm1);

	// try decision and read result kind
	always_comb begin
		interior = (px_k >= KW'(1)) && (px_k <= w_k - KW'(2))
			&& (py_k >= KW'(1)) && (py_k <= h_k - KW'(2));
		lr_bad = (p_q[1] == gms_pkg::CODE_WALL) || (p_q[2] == gms_pkg::CODE_WALL);
		ud_bad = (p_q[3] == gms_pkg::CODE_WALL) || (p_q[4] == gms_pkg::CODE_WALL);
		keep_d = lr_bad ? p_q[3] : p_q[1];
		gone_d = lr_bad ? p_q[4] : p_q[2];
		merge_d = (op_q == gms_pkg::OP_TRY) && interior && (p_q[0] == gms_pkg::CODE_WALL)
			&& !(lr_bad && ud_bad) && (keep_d != gone_d);
		kind_d = gms_pkg::KIND_EMPTY;
		if (op_q == gms_pkg::OP_READ) begin
			if ((px_k >= w_k) || (py_k >= h_k)) begin
				kind_d = gms_pkg::KIND_WALL;
			end else if (p_q[0] == gms_pkg::CODE_WALL) begin
				kind_d = gms_pkg::KIND_WALL;
			end else if (p_q[0] == gms_pkg::CODE_START) begin
				kind_d = gms_pkg::KIND_START;
			end
		end
	end

	// sweep element value
	always_comb begin
		col_open = (x_s1[0] || (x_s1 == wm2)) && (x_s1 != wm1);
		row_open = (y_s1[0] || (y_s1 == hm2)) && (y_s1 != hm1);
		cell_open = col_open && row_open;
		left_lab = (x_s1 != CW'(0)) && gms_pkg::is_label(cb_rd);
		up_lab = (y_s1 != CW'(0)) && gms_pkg::is_label(up_q);
		take_nl = cell_open && !left_lab && !up_lab;
		entry_hit = ((x_s1 == CW'(0)) && (y_s1 == CW'(1))) || ((x_s1 == wm1) && (y_s1 == hm2));
		if (!cell_open) begin
			bval = gms_pkg::CODE_WALL;
		end else if (left_lab) begin
			bval = cb_rd;
		end else if (up_lab) begin
			bval = up_q;
		end else begin
			bval = nl_q;
		end
		if (build_q) begin
			nv = entry_hit ? gms_pkg::CODE_OPEN : bval;
		end else if (relabel_q && (mem_rd == gone_q)) begin
			nv = keep_q;
		end else begin
			nv = mem_rd;
		end
	end

	// next state and memory ports
	always_comb begin
		state_d = state_q;
		mem_we = 1'b0;
		mem_waddr = {x_s1, y_s1};
		mem_wdata = nv;
		mem_raddr = {sx_q, sy_q};
		cb_we = 1'b0;
		unique case (state_q)
			gms_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = gms_pkg::ST_PROBE;
				end
			end
			gms_pkg::ST_PROBE: begin
				unique case (pc_q)
					3'd0: mem_raddr = {cx, cy};
					3'd1: mem_raddr = {cx - CW'(1), cy};
					3'd2: mem_raddr = {cx + CW'(1), cy};
					3'd3: mem_raddr = {cx, cy - CW'(1)};
					default: mem_raddr = {cx, cy + CW'(1)};
				endcase
				if (pc_q == 3'd5) begin
					state_d = gms_pkg::ST_DECIDE;
				end
			end
			gms_pkg::ST_DECIDE: begin
				mem_we = merge_d;
				mem_waddr = {cx, cy};
				mem_wdata = keep_d;
				state_d = gms_pkg::ST_SWEEP;
			end
			gms_pkg::ST_SWEEP: begin
				mem_we = v_s1 && (build_q || (relabel_q && (mem_rd == gone_q)));
				cb_we = v_s1 && build_q;
				if (v_s1 && last_s1) begin
					state_d = gms_pkg::ST_FINISH;
				end
			end
			gms_pkg::ST_FINISH: begin
				mem_we = ok_q && (build_q || relabel_q);
				mem_waddr = {CW'(0), CW'(1)};
				mem_wdata = gms_pkg::CODE_START;
				if (out_free) begin
					state_d = gms_pkg::ST_IDLE;
				end
			end
			default: state_d = gms_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gms_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q <= 6'd63;
			grid_height_q <= 6'd63;
		end else if (cfg_we) begin
			if (cfg_index == gms_pkg::REG_GRID_WIDTH) begin
				grid_width_q <= cfg_data;
			end
			if (cfg_index == gms_pkg::REG_GRID_HEIGHT) begin
				grid_height_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
			issue_q <= 1'b0;
			v_s1 <= 1'b0;
			build_q <= 1'b0;
			relabel_q <= 1'b0;
			nl_q <= LW'(1);
			have_q <= 1'b0;
			ok_q <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == gms_pkg::ST_FINISH) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				gms_pkg::ST_IDLE: begin
					pc_q <= '0;
				end
				gms_pkg::ST_PROBE: begin
					pc_q <= pc_q + 3'd1;
				end
				gms_pkg::ST_DECIDE: begin
					issue_q <= 1'b1;
					v_s1 <= 1'b0;
					have_q <= 1'b0;
					ok_q <= 1'b1;
					build_q <= (op_q == gms_pkg::OP_START);
					relabel_q <= merge_d;
					if (op_q == gms_pkg::OP_START) begin
						nl_q <= LW'(1);
					end
				end
				gms_pkg::ST_SWEEP: begin
					v_s1 <= issue_q;
					if (issue_q && sweep_last) begin
						issue_q <= 1'b0;
					end
					if (v_s1) begin
						if (build_q && take_nl) begin
							nl_q <= nl_q + LW'(1);
						end
						if (gms_pkg::is_label(nv)) begin
							if (!have_q) begin
								have_q <= 1'b1;
							end else if (nv != first_q) begin
								ok_q <= 1'b0;
							end
						end
					end
				end
				default: pc_q <= '0;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= opcode;
			px_q <= pos_x;
			py_q <= pos_y;
		end
		if ((state_q == gms_pkg::ST_PROBE) && (pc_q != 3'd0)) begin
			p_q[pc_q - 3'd1] <= mem_rd;
		end
		if (state_q == gms_pkg::ST_DECIDE) begin
			keep_q <= keep_d;
			gone_q <= gone_d;
			kind_q <= kind_d;
			sx_q <= '0;
			sy_q <= '0;
		end
		if (state_q == gms_pkg::ST_SWEEP) begin
			if (issue_q) begin
				x_s1 <= sx_q;
				y_s1 <= sy_q;
				last_s1 <= sweep_last;
				if (sy_q == hm1) begin
					sy_q <= '0;
					sx_q <= sx_q + CW'(1);
				end else begin
					sy_q <= sy_q + CW'(1);
				end
			end
			if (v_s1) begin
				up_q <= bval;
				if (!have_q) begin
					first_q <= nv;
				end
			end
		end
		if ((state_q == gms_pkg::ST_FINISH) && out_free) begin
			cell_kind_q <= kind_q;
			merged_q <= relabel_q;
			done_res_q <= ok_q;
		end
	end

	gms_ram #(
		.DW(LW),
		.AW(AW)
	) u_label_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rd)
	);

	gms_ram #(
		.DW(LW),
		.AW(CW)
	) u_column_ram (
		.clk   (clk),
		.we    (cb_we),
		.waddr (y_s1),
		.wdata (bval),
		.raddr (sy_q),
		.rdata (cb_rd)
	);

	assign out_valid = out_valid_q;
	assign cell_kind = cell_kind_q;
	assign merged    = merged_q;
	assign done_res  = done_res_q;

	`GMS_ASSERT(a_accept_leaves_idle, accept |=> (state_q == gms_pkg::ST_PROBE), "accept did not start probing")
	`GMS_ASSERT(a_finish_holds, (state_q == gms_pkg::ST_FINISH) && !out_free |=> (state_q == gms_pkg::ST_FINISH), "finish left while result held")
	`GMS_ASSERT(a_merge_no_kind, out_valid && merged |-> (cell_kind == gms_pkg::KIND_EMPTY), "merge reported with a cell kind")
	`GMS_ASSERT(a_store_write_phase, mem_we |-> (state_q == gms_pkg::ST_DECIDE) || (state_q == gms_pkg::ST_SWEEP) || (state_q == gms_pkg::ST_FINISH), "label store written outside work")

endmodule
